@@ rtl/core/dvrt_pkg.sv @@
package dvrt_pkg;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_CLEAR,
        ST_LOAD_B,
        ST_QWAIT,
        ST_SC_START,
        ST_SC_BEST,
        ST_SC_K,
        ST_SC_DRAIN,
        ST_AP_START,
        ST_AP_FW,
        ST_AP_BW,
        ST_DONE
    } state_t;

    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_LOAD  = 2'd1;
    localparam logic [1:0] REQ_ROUND = 2'd2;
    localparam logic [1:0] REQ_QUERY = 2'd3;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_ZERO_COST = 2'd1;
    localparam logic [1:0] STAT_RANGE     = 2'd2;

    localparam logic [16:0] NO_ROUTE   = 17'h1FFFF;
    localparam logic [15:0] DIST_SAT   = 16'hFFFF;
    localparam logic [4:0]  NODE_COUNT_RESET = 5'd16;

endpackage

@@ rtl/core/distance_vector_route_table.sv @@
// channel   | dir | handshake              | payload
// s_axis    | in  | s_axis_tvalid/tready   | tuser: req_type; tdata: node_a, node_b, link_cost
// m_axis    | out | m_axis_tvalid/tready   | tuser: status; tdata: route_dist, route_next
// cfg       | in  | cfg_wr_en              | cfg_wr_data: node_count
//
// one request at a time; a clear walks every one of the MAX_NODES^2 cells
// an exchange round with n active nodes is dominated by the scan through the neighbour loop,
// one table read pair per cycle
// after reset a clearing pass over all MAX_NODES^2 cells runs before the first request is taken
// a result waiting on m_axis holds the block in its final state until taken
module distance_vector_route_table #(
    parameter int MAX_NODES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,   // node_count
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [1:0]  s_axis_tuser,  // req_type
    input  logic [23:0] s_axis_tdata,  // node_a[3:0], node_b[7:4], link_cost[16:8], zero fill
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [1:0]  m_axis_tuser,  // status
    output logic [23:0] m_axis_tdata   // route_dist[16:0], route_next[20:17], zero fill
);

    localparam int IW    = $clog2(MAX_NODES);
    localparam int NW    = $clog2(MAX_NODES + 1);
    localparam int CELLS = MAX_NODES * MAX_NODES;
    localparam int AW    = $clog2(CELLS);
    localparam int PW    = 17 + IW;
    localparam logic [IW-1:0] M_LAST = IW'(MAX_NODES - 1);

    function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] a,
                                                input logic [IW-1:0] b);
        cell_addr = AW'(32'(a) * MAX_NODES + 32'(b));
    endfunction

    dvrt_pkg::state_t state_reg, state_next;

    logic [4:0]          node_count_reg;
    logic [NW-1:0]       n_eff;
    logic [IW-1:0]       n_last;
    logic [IW-1:0]       node_reg, node_next, dest_reg, dest_next, k_reg, k_next;
    logic [IW-1:0]       p_k_reg;
    logic                p_valid_reg;
    logic [1:0]          req_reg, req_next;
    logic [3:0]          a_reg, a_next, b_reg, b_next;
    logic signed [8:0]   cost_reg, cost_next;
    logic [16:0]         best_reg, best_next;
    logic                pv_reg, pv_next;
    logic [15:0]         pd_reg, pd_next;
    logic [IW-1:0]       pn_reg, pn_next;
    logic [1:0]          res_status_reg, res_status_next;
    logic [16:0]         res_dist_reg, res_dist_next;
    logic [3:0]          res_next_reg, res_next_next;
    logic                m_valid_reg, m_valid_next;
    logic [1:0]          m_user_reg, m_user_next;
    logic [23:0]         m_data_reg, m_data_next;

    // table memories
    logic [16:0]   dist_mem [CELLS];
    logic [IW-1:0] next_mem [CELLS];
    logic          nbr_mem  [CELLS];
    logic [PW-1:0] pend_mem [CELLS];

    logic [AW-1:0] rd_a_addr, rd_b_addr, wr_addr, pend_wr_addr, pend_fw_addr, pend_bw_addr;
    logic          dist_we, next_we, nbr_we, pend_we;
    logic [16:0]   dist_wd;
    logic [IW-1:0] next_wd;
    logic          nbr_wd;
    logic [PW-1:0] pend_wd;
    logic [16:0]   rd_a, rd_b;
    logic [IW-1:0] next_rd;
    logic          nbr_rd;
    logic [PW-1:0] pend_fw, pend_bw;

    logic          a_ok, b_ok, cost_pos;
    logic          eval_ok, better, take;
    logic [16:0]   total;
    logic [15:0]   total_sat;
    logic [16:0]   best_new;
    logic          pv_new;
    logic [15:0]   pd_new;
    logic [IW-1:0] pn_new;
    logic [16:0]   ap_dist;
    logic          ap_any;

    assign n_eff  = (32'(node_count_reg) < MAX_NODES) ? NW'(node_count_reg) : NW'(MAX_NODES);
    assign n_last = IW'(32'(n_eff) - 32'd1);
    assign a_ok   = 32'(a_reg) < 32'(n_eff);
    assign b_ok   = 32'(b_reg) < 32'(n_eff);
    assign cost_pos = !cost_reg[8] && (cost_reg != 9'sd0);

    // relaxation of one neighbour, data read in the previous cycle
    assign total     = {1'b0, rd_b[15:0]} + {1'b0, rd_a[15:0]};
    assign total_sat = total[16] ? dvrt_pkg::DIST_SAT : total[15:0];
    assign eval_ok   = nbr_rd && (p_k_reg != dest_reg) && (p_k_reg != node_reg)
                       && (next_rd == p_k_reg) && !rd_a[16] && !rd_b[16];
    assign better    = best_reg[16] || (total_sat < best_reg[15:0]);
    assign take      = p_valid_reg && eval_ok && better;
    assign best_new  = take ? {1'b0, total_sat} : best_reg;
    assign pv_new    = pv_reg | take;
    assign pd_new    = take ? total_sat : pd_reg;
    assign pn_new    = take ? p_k_reg : pn_reg;

    // reverse direction scanned later, its cost wins
    assign ap_any  = pend_fw[PW-1] || pend_bw[PW-1];
    assign ap_dist = pend_bw[PW-1] ? {1'b0, pend_bw[PW-2:IW]} : {1'b0, pend_fw[PW-2:IW]};

    assign s_axis_tready = (state_reg == dvrt_pkg::ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_user_reg;
    assign m_axis_tdata  = m_data_reg;

    assign pend_wr_addr = cell_addr(node_reg, dest_reg);
    assign pend_fw_addr = cell_addr(node_reg, dest_reg);
    assign pend_bw_addr = cell_addr(dest_reg, node_reg);
    assign rd_b_addr    = cell_addr(k_reg, dest_reg);
    assign pend_wd      = {pv_new, pd_new, pn_new};

    always_comb
    begin
        state_next      = state_reg;
        node_next       = node_reg;
        dest_next       = dest_reg;
        k_next          = k_reg;
        req_next        = req_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        cost_next       = cost_reg;
        best_next       = best_reg;
        pv_next         = pv_reg;
        pd_next         = pd_reg;
        pn_next         = pn_reg;
        res_status_next = res_status_reg;
        res_dist_next   = res_dist_reg;
        res_next_next   = res_next_reg;
        m_valid_next    = m_valid_reg && !m_axis_tready;
        m_user_next     = m_user_reg;
        m_data_next     = m_data_reg;
        rd_a_addr       = cell_addr(node_reg, dest_reg);
        wr_addr         = cell_addr(node_reg, dest_reg);
        dist_we         = 1'b0;
        next_we         = 1'b0;
        nbr_we          = 1'b0;
        pend_we         = 1'b0;
        dist_wd         = dvrt_pkg::NO_ROUTE;
        next_wd         = dest_reg;
        nbr_wd          = 1'b0;

        if (p_valid_reg)
        begin
            best_next = best_new;
            pv_next   = pv_new;
            pd_next   = pd_new;
            pn_next   = pn_new;
        end

        unique case (state_reg)
            dvrt_pkg::ST_INIT, dvrt_pkg::ST_CLEAR:
            begin
                dist_we = 1'b1;
                next_we = 1'b1;
                nbr_we  = 1'b1;
                dist_wd = (node_reg == dest_reg) ? 17'd0 : dvrt_pkg::NO_ROUTE;
                next_wd = dest_reg;
                nbr_wd  = 1'b0;
                if (dest_reg == M_LAST)
                begin
                    dest_next = '0;
                    if (node_reg == M_LAST)
                    begin
                        node_next  = '0;
                        state_next = (state_reg == dvrt_pkg::ST_INIT) ? dvrt_pkg::ST_IDLE
                                                                      : dvrt_pkg::ST_DONE;
                    end
                    else
                        node_next = node_reg + IW'(1);
                end
                else
                    dest_next = dest_reg + IW'(1);
            end
            dvrt_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    req_next   = s_axis_tuser;
                    a_next     = s_axis_tdata[3:0];
                    b_next     = s_axis_tdata[7:4];
                    cost_next  = s_axis_tdata[16:8];
                    state_next = dvrt_pkg::ST_DECODE;
                end
            end
            dvrt_pkg::ST_DECODE:
            begin
                res_status_next = dvrt_pkg::STAT_OK;
                res_dist_next   = '0;
                res_next_next   = '0;
                rd_a_addr       = cell_addr(IW'(a_reg), IW'(b_reg));
                wr_addr         = cell_addr(IW'(a_reg), IW'(b_reg));
                node_next       = '0;
                dest_next       = '0;
                unique case (req_reg)
                    dvrt_pkg::REQ_CLEAR:
                        state_next = dvrt_pkg::ST_CLEAR;
                    dvrt_pkg::REQ_LOAD:
                    begin
                        if (!a_ok || !b_ok || a_reg == b_reg)
                        begin
                            res_status_next = dvrt_pkg::STAT_RANGE;
                            state_next      = dvrt_pkg::ST_DONE;
                        end
                        else if (cost_reg == 9'sd0)
                        begin
                            res_status_next = dvrt_pkg::STAT_ZERO_COST;
                            state_next      = dvrt_pkg::ST_DONE;
                        end
                        else
                        begin
                            dist_we    = 1'b1;
                            next_we    = 1'b1;
                            nbr_we     = 1'b1;
                            dist_wd    = cost_pos ? {9'd0, cost_reg[7:0]} : dvrt_pkg::NO_ROUTE;
                            next_wd    = IW'(b_reg);
                            nbr_wd     = cost_pos;
                            state_next = dvrt_pkg::ST_LOAD_B;
                        end
                    end
                    dvrt_pkg::REQ_ROUND:
                        state_next = (32'(n_eff) < 32'd2) ? dvrt_pkg::ST_DONE
                                                          : dvrt_pkg::ST_SC_START;
                    dvrt_pkg::REQ_QUERY:
                    begin
                        if (!a_ok || !b_ok)
                        begin
                            res_status_next = dvrt_pkg::STAT_RANGE;
                            state_next      = dvrt_pkg::ST_DONE;
                        end
                        else
                            state_next = dvrt_pkg::ST_QWAIT;
                    end
                    default: state_next = dvrt_pkg::ST_DONE;
                endcase
            end
            dvrt_pkg::ST_LOAD_B:
            begin
                wr_addr    = cell_addr(IW'(b_reg), IW'(a_reg));
                dist_we    = 1'b1;
                next_we    = 1'b1;
                nbr_we     = 1'b1;
                dist_wd    = cost_pos ? {9'd0, cost_reg[7:0]} : dvrt_pkg::NO_ROUTE;
                next_wd    = IW'(a_reg);
                nbr_wd     = cost_pos;
                state_next = dvrt_pkg::ST_DONE;
            end
            dvrt_pkg::ST_QWAIT:
            begin
                res_dist_next = rd_a;
                res_next_next = 4'(next_rd);
                state_next    = dvrt_pkg::ST_DONE;
            end
            dvrt_pkg::ST_SC_START, dvrt_pkg::ST_SC_DRAIN:
            begin
                if (state_reg == dvrt_pkg::ST_SC_START && node_reg != dest_reg)
                    state_next = dvrt_pkg::ST_SC_BEST;
                else
                begin
                    pend_we = (state_reg == dvrt_pkg::ST_SC_DRAIN);
                    if (dest_reg == n_last)
                    begin
                        dest_next = '0;
                        if (node_reg == n_last)
                        begin
                            node_next  = '0;
                            dest_next  = IW'(1);
                            state_next = dvrt_pkg::ST_AP_START;
                        end
                        else
                        begin
                            node_next  = node_reg + IW'(1);
                            state_next = dvrt_pkg::ST_SC_START;
                        end
                    end
                    else
                    begin
                        dest_next  = dest_reg + IW'(1);
                        state_next = dvrt_pkg::ST_SC_START;
                    end
                end
            end
            dvrt_pkg::ST_SC_BEST:
            begin
                best_next  = rd_a;
                pv_next    = 1'b0;
                pd_next    = '0;
                pn_next    = '0;
                k_next     = '0;
                state_next = dvrt_pkg::ST_SC_K;
            end
            dvrt_pkg::ST_SC_K:
            begin
                rd_a_addr = cell_addr(node_reg, k_reg);
                k_next    = k_reg + IW'(1);
                if (k_reg == n_last)
                    state_next = dvrt_pkg::ST_SC_DRAIN;
            end
            dvrt_pkg::ST_AP_START:
                state_next = dvrt_pkg::ST_AP_FW;
            dvrt_pkg::ST_AP_FW:
            begin
                wr_addr    = cell_addr(node_reg, dest_reg);
                dist_we    = ap_any;
                next_we    = pend_fw[PW-1];
                dist_wd    = ap_dist;
                next_wd    = pend_fw[IW-1:0];
                state_next = dvrt_pkg::ST_AP_BW;
            end
            dvrt_pkg::ST_AP_BW:
            begin
                wr_addr    = cell_addr(dest_reg, node_reg);
                dist_we    = ap_any;
                next_we    = pend_bw[PW-1];
                dist_wd    = ap_dist;
                next_wd    = pend_bw[IW-1:0];
                state_next = dvrt_pkg::ST_AP_START;
                if (dest_reg == n_last)
                begin
                    if (node_reg == n_last - IW'(1))
                        state_next = dvrt_pkg::ST_DONE;
                    else
                    begin
                        node_next = node_reg + IW'(1);
                        dest_next = node_reg + IW'(2);
                    end
                end
                else
                    dest_next = dest_reg + IW'(1);
            end
            dvrt_pkg::ST_DONE:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_user_next  = res_status_reg;
                    m_data_next  = {3'd0, res_next_reg, res_dist_reg};
                    state_next   = dvrt_pkg::ST_IDLE;
                end
            end
            default: state_next = dvrt_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= dvrt_pkg::ST_INIT;
            node_count_reg <= dvrt_pkg::NODE_COUNT_RESET;
            node_reg       <= '0;
            dest_reg       <= '0;
            k_reg          <= '0;
            p_valid_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            node_reg    <= node_next;
            dest_reg    <= dest_next;
            k_reg       <= k_next;
            p_valid_reg <= (state_reg == dvrt_pkg::ST_SC_K);
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en)
                node_count_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        p_k_reg        <= k_reg;
        req_reg        <= req_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        cost_reg       <= cost_next;
        best_reg       <= best_next;
        pv_reg         <= pv_next;
        pd_reg         <= pd_next;
        pn_reg         <= pn_next;
        res_status_reg <= res_status_next;
        res_dist_reg   <= res_dist_next;
        res_next_reg   <= res_next_next;
        m_user_reg     <= m_user_next;
        m_data_reg     <= m_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (dist_we)
            dist_mem[wr_addr] <= dist_wd;
        if (next_we)
            next_mem[wr_addr] <= next_wd;
        if (nbr_we)
            nbr_mem[wr_addr] <= nbr_wd;
        rd_a    <= dist_mem[rd_a_addr];
        rd_b    <= dist_mem[rd_b_addr];
        next_rd <= next_mem[rd_a_addr];
        nbr_rd  <= nbr_mem[rd_a_addr];
    end

    always_ff @(posedge clk)
    begin
        if (pend_we)
            pend_mem[pend_wr_addr] <= pend_wd;
        if (state_reg == dvrt_pkg::ST_AP_START)
        begin
            pend_fw <= pend_mem[pend_fw_addr];
            pend_bw <= pend_mem[pend_bw_addr];
        end
    end

    // the table snapshot must not change while a round is scanning
    a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dvrt_pkg::ST_SC_START || state_reg == dvrt_pkg::ST_SC_BEST ||
         state_reg == dvrt_pkg::ST_SC_K || state_reg == dvrt_pkg::ST_SC_DRAIN)
        |-> !dist_we && !next_we && !nbr_we)
        else $error("table written during round scan");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != dvrt_pkg::STAT_OK |-> m_axis_tdata == 24'd0)
        else $error("rejected request returned route data");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while previous one in progress");

endmodule
